// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int POS_OUT_W  = 11;
    localparam int CELL_W     = 16;
    localparam int INDEX_W    = 11;

    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [7:0]        NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]        SPACE_CODE   = 8'h20;
    localparam logic [7:0]        ATTR_RESET   = 8'h07;

    localparam logic [0:0] REG_TEXT_ATTR = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCROLL,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic exec_read;
        logic exec_put;
        logic rd_capture;
        logic clr_step;
        logic scr_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
        logic need_scroll;
        logic cnt_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic single write port RAM with registered read.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine for the text console writer.
module tcw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcw_pkg::t_dp_sts  i_sts,
    output tcw_pkg::t_dp_cmd  o_cmd
);

    import tcw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.is_read) begin
                    n_state = ST_RDWAIT;
                end else if (i_sts.need_scroll) begin
                    n_state = ST_SCROLL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RDWAIT: n_state = ST_DONE;
            ST_SCROLL: begin
                if (i_sts.cnt_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec_read = i_sts.is_read;
                o_cmd.exec_put  = !i_sts.is_read;
            end
            ST_RDWAIT: o_cmd.rd_capture = 1'b1;
            ST_SCROLL: o_cmd.scr_step = 1'b1;
            ST_DRAIN: o_cmd = '0;
            ST_DONE: o_cmd.load_out = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/tcw_dp.sv =====
// Datapath: cursor, copy counter, screen store access and result register.
module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcw_pkg::t_dp_cmd                  i_cmd,
    output tcw_pkg::t_dp_sts                  o_sts,
    input  logic                              i_in_cmd,
    input  logic [7:0]                        i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]       i_cell_index,
    input  logic [7:0]                        i_attr,
    output logic                              o_ram_we,
    output logic [$clog2(COLUMNS*ROWS)-1:0]   o_ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0]        o_ram_wdata,
    output logic [$clog2(COLUMNS*ROWS)-1:0]   o_ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]        i_ram_rdata,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [tcw_pkg::ROW_OUT_W-1:0]     o_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]     o_cursor_col,
    output logic [tcw_pkg::POS_OUT_W-1:0]     o_cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]        o_cell_value,
    output logic                              o_scrolled
);

    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic                 r_cmd;
    logic [7:0]           r_char;
    logic [INDEX_W-1:0]   r_index;
    logic                 r_rd_ok;
    logic [CELL_W-1:0]    r_cell;
    logic                 r_scr;
    logic [ADDR_W-1:0]    r_cnt;
    logic                 r_cp_vld;
    logic [ADDR_W-1:0]    r_cp_addr;
    logic                 r_cp_fill;
    logic                 r_out_valid;
    logic [ROW_OUT_W-1:0] r_o_row;
    logic [COL_OUT_W-1:0] r_o_col;
    logic [POS_OUT_W-1:0] r_o_pos;
    logic [CELL_W-1:0]    r_o_cell;
    logic                 r_o_scr;

    logic [ADDR_W-1:0] w_cur;
    logic              w_is_nl;
    logic [COL_W:0]    w_col_inc;
    logic              w_col_wrap;
    logic              w_row_last;
    logic              w_scroll;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic              w_cnt_last;
    logic [ADDR_W:0]   w_src;
    logic              w_fill;
    logic [CELL_W-1:0] w_blank;
    logic [31:0]       w_idx_ext;
    logic [31:0]       w_row_ext;
    logic [31:0]       w_col_ext;
    logic [31:0]       w_pos_ext;

    assign w_cur      = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign w_is_nl    = (r_char == NEWLINE_CODE);
    assign w_col_inc  = (COL_W+1)'(r_col) + (COL_W+1)'(1);
    assign w_col_wrap = w_is_nl || (w_col_inc == (COL_W+1)'(COLUMNS));
    assign w_row_last = (r_row == ROW_W'(ROWS - 1));
    assign w_scroll   = w_col_wrap && w_row_last;
    assign n_col      = w_col_wrap ? '0 : w_col_inc[COL_W-1:0];
    assign n_row      = (w_col_wrap && !w_row_last) ? r_row + ROW_W'(1) : r_row;
    assign w_cnt_last = (r_cnt == ADDR_W'(CELLS - 1));
    assign w_src      = (ADDR_W+1)'(r_cnt) + (ADDR_W+1)'(COLUMNS);
    assign w_fill     = (r_cnt >= ADDR_W'(CELLS - COLUMNS));
    assign w_blank    = {i_attr, SPACE_CODE};
    assign w_idx_ext  = 32'(r_index);
    assign w_row_ext  = 32'(r_row);
    assign w_col_ext  = 32'(r_col);
    assign w_pos_ext  = 32'(w_cur);

    always_comb begin
        if (i_cmd.exec_read) begin
            o_ram_raddr = w_idx_ext[ADDR_W-1:0];
        end else if (w_fill) begin
            o_ram_raddr = r_cnt;
        end else begin
            o_ram_raddr = w_src[ADDR_W-1:0];
        end
    end

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_cnt;
        o_ram_wdata = BLANK_CELL;
        if (i_cmd.clr_step) begin
            o_ram_we = 1'b1;
        end else if (i_cmd.exec_put && !w_is_nl) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = w_cur;
            o_ram_wdata = {i_attr, r_char};
        end else if (r_cp_vld) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_cp_addr;
            o_ram_wdata = r_cp_fill ? w_blank : i_ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_cp_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec_put) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_cmd.exec_read || i_cmd.exec_put) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step || i_cmd.scr_step) begin
                r_cnt <= r_cnt + ADDR_W'(1);
            end
            r_cp_vld <= i_cmd.scr_step;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd   <= i_in_cmd;
            r_char  <= i_char_code;
            r_index <= i_cell_index;
            r_rd_ok <= (32'(i_cell_index) < 32'(CELLS));
        end
        if (i_cmd.exec_put) begin
            r_cell <= '0;
            r_scr  <= w_scroll;
        end
        if (i_cmd.exec_read) begin
            r_scr <= 1'b0;
        end
        if (i_cmd.rd_capture) begin
            r_cell <= r_rd_ok ? i_ram_rdata : '0;
        end
        r_cp_addr <= r_cnt;
        r_cp_fill <= w_fill;
        if (i_cmd.load_out) begin
            r_o_row  <= w_row_ext[ROW_OUT_W-1:0];
            r_o_col  <= w_col_ext[COL_OUT_W-1:0];
            r_o_pos  <= w_pos_ext[POS_OUT_W-1:0];
            r_o_cell <= r_cell;
            r_o_scr  <= r_scr;
        end
    end

    assign o_sts.is_read     = r_cmd;
    assign o_sts.need_scroll = w_scroll;
    assign o_sts.cnt_last    = w_cnt_last;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_cursor_pos = r_o_pos;
    assign o_cell_value = r_o_cell;
    assign o_scrolled   = r_o_scr;

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: register port, controller, datapath and screen store.
// A put word passes through the EXEC and DONE states before its result is loaded for output,
// a read word through EXEC, RDWAIT and DONE; a put that scrolls also passes through SCROLL
// and DRAIN, which copy the store up one row at one cell per cycle. A new word is accepted
// only in IDLE, after the previous result is loaded. After reset a clearing pass fills the
// store with blanks, and no word is accepted until it ends; register writes are taken at any time.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [7:0]                        i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]       i_cell_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [tcw_pkg::ROW_OUT_W-1:0]     o_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]     o_cursor_col,
    output logic [tcw_pkg::POS_OUT_W-1:0]     o_cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]        o_cell_value,
    output logic                              o_scrolled
);

    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [7:0]        r_attr;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [CELL_W-1:0] w_ram_wdata;
    logic [ADDR_W-1:0] w_ram_raddr;
    logic [CELL_W-1:0] w_ram_rdata;
    logic              w_reg_sel;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2:2] == REG_TEXT_ATTR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_attr <= pwdata[7:0];
        end
    end

    assign prdata = w_reg_sel ? {24'd0, r_attr} : 32'd0;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_cmd     (i_cmd),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_attr       (r_attr),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_value (o_cell_value),
        .o_scrolled   (o_scrolled)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule
